// ===== rtl/core/mpsel_pkg.sv =====
// Package for the multipath source/repair selector.
// Holds field widths, operation codes, register indexes and the microprogram.
// No dependencies.
`default_nettype none

package mpsel_pkg;

  localparam int unsigned NUM_PATHS_DEF = 16;

  localparam int unsigned ID_W    = 4;
  localparam int unsigned RTT_W   = 16;
  localparam int unsigned LOSS_W  = 16;
  localparam int unsigned BW_W    = 20;
  localparam int unsigned CORR_W  = 16;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SCORE_W = BW_W + WGT_W + 2;
  localparam int unsigned MAG_W   = CORR_W + 1;
  localparam int unsigned IN_W    = 80;
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WPATH  = 2'd0,
    FUNC_WCORR  = 2'd1,
    FUNC_SOURCE = 2'd2,
    FUNC_REPAIR = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RTT_WGT  = 2'd0,
    REG_LOSS_WGT = 2'd1,
    REG_BW_WGT   = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef logic [3:0] step_t;

  localparam step_t ST_CLEAR   = 4'd0;
  localparam step_t ST_IDLE    = 4'd1;
  localparam step_t ST_WPATH   = 4'd2;
  localparam step_t ST_WCOR_AB = 4'd3;
  localparam step_t ST_WCOR_BA = 4'd4;
  localparam step_t ST_INIT    = 4'd5;
  localparam step_t ST_READ    = 4'd6;
  localparam step_t ST_MUL     = 4'd7;
  localparam step_t ST_SUM     = 4'd8;
  localparam step_t ST_CMP     = 4'd9;
  localparam step_t ST_FIN     = 4'd10;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_WPATH, OP_WCOR_AB, OP_WCOR_BA,
    OP_INIT, OP_READ, OP_MUL, OP_SUM, OP_CMP, OP_FIN
  } op_e;

  typedef enum logic [2:0] {
    J_NEXT, J_GOTO, J_DISPATCH, J_SCAN, J_CLEAR, J_RESULT
  } jmp_e;

  typedef struct packed {
    op_e   op;
    jmp_e  jmp;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{op: OP_NONE, jmp: J_GOTO, target: ST_IDLE};
    case (s)
      ST_CLEAR:   c = '{op: OP_CLEAR,   jmp: J_CLEAR,    target: ST_IDLE};
      ST_IDLE:    c = '{op: OP_ACCEPT,  jmp: J_DISPATCH, target: ST_IDLE};
      ST_WPATH:   c = '{op: OP_WPATH,   jmp: J_GOTO,     target: ST_FIN};
      ST_WCOR_AB: c = '{op: OP_WCOR_AB, jmp: J_NEXT,     target: ST_IDLE};
      ST_WCOR_BA: c = '{op: OP_WCOR_BA, jmp: J_GOTO,     target: ST_FIN};
      ST_INIT:    c = '{op: OP_INIT,    jmp: J_NEXT,     target: ST_IDLE};
      ST_READ:    c = '{op: OP_READ,    jmp: J_NEXT,     target: ST_IDLE};
      ST_MUL:     c = '{op: OP_MUL,     jmp: J_NEXT,     target: ST_IDLE};
      ST_SUM:     c = '{op: OP_SUM,     jmp: J_NEXT,     target: ST_IDLE};
      ST_CMP:     c = '{op: OP_CMP,     jmp: J_SCAN,     target: ST_READ};
      ST_FIN:     c = '{op: OP_FIN,     jmp: J_RESULT,   target: ST_IDLE};
      default:    c = '{op: OP_NONE,    jmp: J_GOTO,     target: ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/multipath_source_repair_selector_top.sv =====
// Multipath source/repair path selector, microcoded sequencer over path and correlation RAMs.
// Path writes and correlation writes each run from accept to result valid; a pick initialises,
// then runs the scan loop read/mul/sum/compare once per path before the final step.
// A new word is accepted the cycle after the previous result is loaded into the output register.
// Reset: weights take their reset values, all paths invalid; then a clearing pass zeroes
// every entry of the correlation RAM with s_axis_tready low.
// Depends on mpsel_pkg.
`default_nettype none

module multipath_source_repair_selector_top #(
  parameter int unsigned NUM_PATHS = mpsel_pkg::NUM_PATHS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // func[1:0] path_id[5:2] other_path[9:6] rtt_value[25:10] loss_value[41:26]
  // bandwidth_value[61:42] correlation_value[77:62], zero pad[79:78]
  input  wire logic [mpsel_pkg::IN_W-1:0]    s_axis_tdata,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // chosen_path[3:0] status[4], zero pad[7:5]
  output      logic [mpsel_pkg::OUT_W-1:0]   m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [mpsel_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mpsel_pkg::WGT_W-1:0]   cfg_data_i
);
  import mpsel_pkg::*;

  localparam int unsigned PW     = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int unsigned AW     = ((PW > ID_W) ? PW : ID_W) + 1;
  localparam int unsigned CDEPTH = NUM_PATHS * NUM_PATHS;
  localparam int unsigned CW     = $clog2(CDEPTH);
  localparam int unsigned XW     = CW + AW;
  localparam int unsigned PM_W   = RTT_W + LOSS_W + BW_W;
  localparam logic [PW-1:0] IDX_LAST = PW'(NUM_PATHS - 1);
  localparam logic [CW-1:0] CLR_LAST = CW'(CDEPTH - 1);
  localparam logic [AW-1:0] N_EXT    = AW'(NUM_PATHS);
  localparam logic [MAG_W-1:0] MAG_INIT = MAG_W'(32768);

  // sequencer
  step_t pc_q, pc_d;
  ctrl_t uc;
  logic  in_acc, out_free;

  // item and config registers
  func_e               func_q;
  logic [ID_W-1:0]     pa_q, pb_q;
  logic [RTT_W-1:0]    rtt_q;
  logic [LOSS_W-1:0]   loss_q;
  logic [BW_W-1:0]     bw_q;
  logic [CORR_W-1:0]   corr_q;
  logic [WGT_W-1:0]    rtt_wgt_q, loss_wgt_q, bw_wgt_q;

  // stores
  logic [NUM_PATHS-1:0] valid_q;
  logic [PM_W-1:0]      path_mem [NUM_PATHS];
  logic [CORR_W-1:0]    corr_mem [CDEPTH];
  logic [PM_W-1:0]      pm_rd_q;
  logic [CORR_W-1:0]    cm_rd_q;
  logic                 vld_rd_q;
  logic                 cm_we;
  logic [CW-1:0]        cm_waddr, cm_raddr, clr_q;
  logic [CORR_W-1:0]    cm_wdata;

  // scan datapath
  logic [PW-1:0]              idx_q;
  logic [BW_W+WGT_W-1:0]      prod_bw_q;
  logic [RTT_W+WGT_W-1:0]     prod_rtt_q;
  logic [LOSS_W+WGT_W-1:0]    prod_loss_q;
  logic signed [SCORE_W-1:0]  score_q, top_score_q;
  logic [MAG_W-1:0]           mag_q, mag_s1_q, best_mag_q, mag_c;
  logic                       vld_s1_q, vld_s2_q;
  logic [1:0]                 cnt_q;
  logic [PW-1:0]              first_q, src_q, rep_q, fb_q;
  logic                       have_src_q, found_q, have_fb_q;

  // output register
  logic            out_valid_q;
  logic [ID_W-1:0] out_chosen_q;
  logic            out_status_q;

  logic [AW-1:0] pa_ext, pb_ext;
  logic          pa_ok, pb_ok;
  logic [PW-1:0] pa_addr, pb_addr;
  logic [MAG_W-1:0] corr_sx;

  assign uc       = ucode(pc_q);
  assign s_axis_tready = (uc.op == OP_ACCEPT);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign pa_ext  = AW'(pa_q);
  assign pb_ext  = AW'(pb_q);
  assign pa_ok   = pa_ext < N_EXT;
  assign pb_ok   = pb_ext < N_EXT;
  assign pa_addr = pa_ext[PW-1:0];
  assign pb_addr = pb_ext[PW-1:0];

  always_comb begin
    pc_d = pc_q;
    unique case (uc.jmp)
      J_NEXT:   pc_d = pc_q + 4'd1;
      J_GOTO:   pc_d = uc.target;
      J_DISPATCH: begin
        if (in_acc) begin
          unique case (func_e'(s_axis_tdata[1:0]))
            FUNC_WPATH: pc_d = ST_WPATH;
            FUNC_WCORR: pc_d = ST_WCOR_AB;
            default:    pc_d = ST_INIT;
          endcase
        end
      end
      J_SCAN:   pc_d = (idx_q == IDX_LAST) ? pc_q + 4'd1 : uc.target;
      J_CLEAR:  if (clr_q == CLR_LAST) pc_d = uc.target;
      J_RESULT: if (out_free) pc_d = uc.target;
      default:  pc_d = ST_IDLE;
    endcase
  end

  // correlation RAM port control
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = clr_q;
    cm_wdata = '0;
    unique case (uc.op)
      OP_CLEAR: cm_we = 1'b1;
      OP_WCOR_AB: begin
        cm_we    = pa_ok && pb_ok;
        cm_waddr = CW'(XW'(pa_addr) * XW'(NUM_PATHS) + XW'(pb_addr));
        cm_wdata = corr_q;
      end
      OP_WCOR_BA: begin
        cm_we    = pa_ok && pb_ok;
        cm_waddr = CW'(XW'(pb_addr) * XW'(NUM_PATHS) + XW'(pa_addr));
        cm_wdata = corr_q;
      end
      default: cm_we = 1'b0;
    endcase
  end

  assign cm_raddr = CW'(XW'(pb_ext) * XW'(NUM_PATHS) + XW'(idx_q));

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      corr_mem[cm_waddr] <= cm_wdata;
    end
    if (uc.op == OP_READ) begin
      cm_rd_q <= corr_mem[cm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.op == OP_WPATH && pa_ok) begin
      path_mem[pa_addr] <= {bw_q, loss_q, rtt_q};
    end
    if (uc.op == OP_READ) begin
      pm_rd_q <= path_mem[idx_q];
    end
  end

  assign corr_sx = {cm_rd_q[CORR_W-1], cm_rd_q};
  assign mag_c   = corr_sx[MAG_W-1] ? (MAG_W'(0) - corr_sx) : corr_sx;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(s_axis_tdata[1:0]);
      pa_q   <= s_axis_tdata[5:2];
      pb_q   <= s_axis_tdata[9:6];
      rtt_q  <= s_axis_tdata[25:10];
      loss_q <= s_axis_tdata[41:26];
      bw_q   <= s_axis_tdata[61:42];
      corr_q <= s_axis_tdata[77:62];
    end
    if (uc.op == OP_MUL) begin
      prod_bw_q   <= pm_rd_q[PM_W-1 -: BW_W] * bw_wgt_q;
      prod_loss_q <= pm_rd_q[RTT_W +: LOSS_W] * loss_wgt_q;
      prod_rtt_q  <= pm_rd_q[RTT_W-1:0] * rtt_wgt_q;
      mag_s1_q    <= pb_ok ? mag_c : '0;
      vld_s1_q    <= vld_rd_q;
    end
    if (uc.op == OP_SUM) begin
      score_q  <= $signed({2'b00, prod_bw_q}) - $signed({6'd0, prod_rtt_q})
                - $signed({6'd0, prod_loss_q});
      mag_q    <= mag_s1_q;
      vld_s2_q <= vld_s1_q;
    end
    if (uc.op == OP_READ) begin
      vld_rd_q <= valid_q[idx_q];
    end
  end

  // control and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= ST_CLEAR;
      clr_q        <= '0;
      valid_q      <= '0;
      rtt_wgt_q    <= WGT_W'(1638);
      loss_wgt_q   <= WGT_W'(500);
      bw_wgt_q     <= WGT_W'(410);
      idx_q        <= '0;
      cnt_q        <= '0;
      first_q      <= '0;
      src_q        <= '0;
      rep_q        <= '0;
      fb_q         <= '0;
      have_src_q   <= 1'b0;
      found_q      <= 1'b0;
      have_fb_q    <= 1'b0;
      top_score_q  <= '0;
      best_mag_q   <= MAG_INIT;
      out_valid_q  <= 1'b0;
      out_chosen_q <= '0;
      out_status_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_RTT_WGT:  rtt_wgt_q  <= cfg_data_i;
          REG_LOSS_WGT: loss_wgt_q <= cfg_data_i;
          REG_BW_WGT:   bw_wgt_q   <= cfg_data_i;
          default:      ;
        endcase
      end
      // in the final step a ready sink always finds the register free
      if (m_axis_tready && uc.op != OP_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (uc.op)
        OP_CLEAR: clr_q <= clr_q + CW'(1);
        OP_WPATH: if (pa_ok) valid_q[pa_addr] <= 1'b1;
        OP_INIT: begin
          idx_q      <= '0;
          cnt_q      <= '0;
          have_src_q <= 1'b0;
          found_q    <= 1'b0;
          have_fb_q  <= 1'b0;
          best_mag_q <= MAG_INIT;
        end
        OP_CMP: begin
          idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + PW'(1);
          if (vld_s2_q) begin
            if (cnt_q != 2'd2) cnt_q <= cnt_q + 2'd1;
            if (cnt_q == 2'd0) first_q <= idx_q;
            if (!have_src_q || score_q > top_score_q) begin
              have_src_q  <= 1'b1;
              top_score_q <= score_q;
              src_q       <= idx_q;
            end
            if (AW'(idx_q) != pb_ext) begin
              if (!have_fb_q) begin
                have_fb_q <= 1'b1;
                fb_q      <= idx_q;
              end
              if (mag_q < best_mag_q) begin
                best_mag_q <= mag_q;
                rep_q      <= idx_q;
                found_q    <= 1'b1;
              end
            end
          end
        end
        OP_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            priority if (func_q == FUNC_WPATH || func_q == FUNC_WCORR) begin
              out_chosen_q <= '0;
              out_status_q <= 1'b0;
            end else if (cnt_q == 2'd0) begin
              out_chosen_q <= '0;
              out_status_q <= 1'b1;
            end else if (func_q == FUNC_SOURCE) begin
              out_chosen_q <= ID_W'(src_q);
              out_status_q <= 1'b0;
            end else if (cnt_q == 2'd1) begin
              out_chosen_q <= ID_W'(first_q);
              out_status_q <= 1'b0;
            end else begin
              out_chosen_q <= found_q ? ID_W'(rep_q) : ID_W'(fb_q);
              out_status_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_status_q, out_chosen_q};

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during correlation clear");

  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == ST_FIN))
    else $error("result loaded outside final step");

  a_err_zero_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_chosen_q == '0))
    else $error("error result carries a path id");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LAST)
    else $error("scan index past last path");

  a_cnt_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("valid count overflow");

endmodule

`default_nettype wire
